FILE: design/pitched_sample_player_core_macros.svh
`ifndef PITCHED_SAMPLE_PLAYER_CORE_MACROS_SVH
`define PITCHED_SAMPLE_PLAYER_CORE_MACROS_SVH

// same-cycle implication
`define PSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psp assertion failed");

// next-cycle implication
`define PSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psp assertion failed");

`endif

FILE: design/psp_pkg.sv
package psp_pkg;

   localparam int DEFAULT_SAMPLE_DEPTH = 2048;

   localparam int NOTE_W      = 7;
   localparam int COUNT_W     = 12;
   localparam int VOLUME_W    = 7;
   localparam int LOAD_ADDR_W = 11;
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = 21;
   localparam int SEMI_W      = 17;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // register indexes (paddr[4:2])
   localparam logic [2:0] CSR_TARGET_NOTE  = 3'd0;
   localparam logic [2:0] CSR_BASE_NOTE    = 3'd1;
   localparam logic [2:0] CSR_SAMPLE_COUNT = 3'd2;
   localparam logic [2:0] CSR_SOUND_ENABLE = 3'd3;
   localparam logic [2:0] CSR_VOLUME       = 3'd4;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_BEAT   = 2'd1;
   localparam logic [1:0] REQ_LOAD   = 2'd2;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_RESTART,
      OP_LOAD
   } op_type;

   typedef enum logic {
      BK_FIRST,
      BK_SECOND
   } back_state_type;

   typedef struct packed {
      op_type                         op;
      logic [LOAD_ADDR_W-1:0]         load_address;
      logic signed [SAMPLE_W-1:0]     load_data;
   } queue_entry_type;

   typedef struct packed {
      logic [STEP_W-1:0]  step;
      logic [COUNT_W-1:0] eff_count;
   } play_cfg_type;

   function automatic logic [SEMI_W-1:0] semitone_q16(input logic [3:0] semi);
      logic [SEMI_W-1:0] v;
      case (semi)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd69433;
         4'd2:    v = 17'd73562;
         4'd3:    v = 17'd77936;
         4'd4:    v = 17'd82570;
         4'd5:    v = 17'd87480;
         4'd6:    v = 17'd92682;
         4'd7:    v = 17'd98193;
         4'd8:    v = 17'd104032;
         4'd9:    v = 17'd110218;
         4'd10:   v = 17'd116772;
         4'd11:   v = 17'd123715;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

   // 2^((pitch-base)/12) in unsigned 5.16, octave shift clamped to four
   function automatic logic [STEP_W-1:0] pitch_step(input logic [NOTE_W-1:0] pitch,
                                                    input logic [NOTE_W-1:0] base);
      logic [8:0]        d;
      logic [16:0]       prod;
      logic [4:0]        q;
      logic [8:0]        rem;
      logic [4:0]        sh;
      logic [STEP_W-1:0] s;
      logic [STEP_W-1:0] r;
      d    = 9'(pitch) + 9'd132 - 9'(base);
      prod = 17'(d) * 17'd171;
      q    = prod[15:11];
      rem  = d - 9'(q) * 9'd12;
      s    = STEP_W'(semitone_q16(rem[3:0]));
      if (q > 5'd11) begin
         sh = q - 5'd11;
         if (sh > 5'd4) begin
            sh = 5'd4;
         end
         r = s << sh[2:0];
      end else begin
         sh = 5'd11 - q;
         if (sh > 5'd4) begin
            sh = 5'd4;
         end
         r = s >> sh[2:0];
      end
      return r;
   endfunction

endpackage

FILE: design/psp_req_if.sv
interface psp_req_if import psp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic                       muted;
   logic [LOAD_ADDR_W-1:0]     load_address;
   logic signed [SAMPLE_W-1:0] load_data;

   modport source (output valid, req_type, muted, load_address, load_data, input ready);
   modport sink   (input valid, req_type, muted, load_address, load_data, output ready);
endinterface

FILE: design/psp_rsp_if.sv
interface psp_rsp_if import psp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_sample;
   logic                       playing;

   modport source (output valid, audio_sample, playing, input ready);
   modport sink   (input valid, audio_sample, playing, output ready);
endinterface

FILE: design/pitched_sample_player_core.sv
// Pitched sample player, one-shot playback of a stored 16-bit PCM sample.
// req_chan (valid/ready) takes three kinds of transaction: load sample word,
// beat (restart playback at position zero) and sample request. Only sample
// requests produce a transaction on rsp_chan: one interpolated sample, or
// zero with playing low once the position is past the last sample pair.
// Registers (target note, base note, sample count, sound enable, volume) sit
// on the csr_ APB port at 4-byte spacing; write them only while idle.
// A playing sample reads its lower word, then its upper word into the x stage;
// silence enters the x stage directly; both leave through the output register.
// Loads and beats are taken one per cycle while the queue has room; a sample
// request waits for both reads of the last on the single sample-memory port.
// A 4-entry queue parts intake from execution, so req_chan keeps taking
// transactions while a result waits on a stalled receiver; when the queue
// fills, req_chan.ready drops. rsp_chan holds its transaction until taken.
// Reset clears the queue and pipeline and puts the position at the end of
// the sample (silent); sample memory contents are undefined until written.
`include "pitched_sample_player_core_macros.svh"

module pitched_sample_player_core import psp_pkg::*; #(
   parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   psp_req_if.sink               req_chan,
   psp_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [NOTE_W-1:0]   target_note_ff, target_note_in;
   logic [NOTE_W-1:0]   base_note_ff, base_note_in;
   logic [COUNT_W-1:0]  sample_count_ff, sample_count_in;
   logic                sound_enable_ff, sound_enable_in;
   logic [VOLUME_W-1:0] volume_ff, volume_in;
   play_cfg_type        play_cfg_ff, play_cfg_in;

   logic            csr_write;
   logic            beat_allowed;
   logic            push;
   queue_entry_type push_entry;
   logic            q_full;
   logic            q_empty;
   logic            pop;
   queue_entry_type head;
   logic            rsp_silent;
   logic            sample_accept;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      target_note_in  = target_note_ff;
      base_note_in    = base_note_ff;
      sample_count_in = sample_count_ff;
      sound_enable_in = sound_enable_ff;
      volume_in       = volume_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            CSR_TARGET_NOTE:  target_note_in  = csr_pwdata[NOTE_W-1:0];
            CSR_BASE_NOTE:    base_note_in    = csr_pwdata[NOTE_W-1:0];
            CSR_SAMPLE_COUNT: sample_count_in = csr_pwdata[COUNT_W-1:0];
            CSR_SOUND_ENABLE: sound_enable_in = csr_pwdata[0];
            CSR_VOLUME:       volume_in       = csr_pwdata[VOLUME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         CSR_TARGET_NOTE:  csr_prdata = CSR_DATA_W'(target_note_ff);
         CSR_BASE_NOTE:    csr_prdata = CSR_DATA_W'(base_note_ff);
         CSR_SAMPLE_COUNT: csr_prdata = CSR_DATA_W'(sample_count_ff);
         CSR_SOUND_ENABLE: csr_prdata = CSR_DATA_W'(sound_enable_ff);
         CSR_VOLUME:       csr_prdata = CSR_DATA_W'(volume_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // pitch step and clamped count, refreshed every cycle
   always_comb begin
      play_cfg_in.step = pitch_step(target_note_ff, base_note_ff);
      if (int'(sample_count_ff) > SAMPLE_DEPTH) begin
         play_cfg_in.eff_count = COUNT_W'(SAMPLE_DEPTH);
      end else begin
         play_cfg_in.eff_count = sample_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_note_ff  <= NOTE_W'(69);
         base_note_ff    <= NOTE_W'(69);
         sample_count_ff <= COUNT_W'(2048);
         sound_enable_ff <= 1'b1;
         volume_ff       <= VOLUME_W'(100);
      end else begin
         target_note_ff  <= target_note_in;
         base_note_ff    <= base_note_in;
         sample_count_ff <= sample_count_in;
         sound_enable_ff <= sound_enable_in;
         volume_ff       <= volume_in;
      end
   end

   always_ff @(posedge clock) begin
      play_cfg_ff <= play_cfg_in;
   end

   assign beat_allowed = sound_enable_ff && (volume_ff != '0);

   psp_front #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_front (
      .req_chan     (req_chan),
      .beat_allowed (beat_allowed),
      .q_full       (q_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   psp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty)
   );

   psp_back #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .pop      (pop),
      .play_cfg (play_cfg_ff),
      .rsp_chan (rsp_chan)
   );

   assign rsp_silent    = rsp_chan.valid && !rsp_chan.playing;
   assign sample_accept = req_chan.valid && req_chan.ready &&
                          (req_chan.req_type == REQ_SAMPLE);

   `PSP_ASSERT_IMPL(a_pop_needs_entry, clock, reset, pop, !q_empty)
   `PSP_ASSERT_IMPL(a_silence_is_zero, clock, reset, rsp_silent, rsp_chan.audio_sample == '0)
   `PSP_ASSERT_NEXT(a_sample_req_queued, clock, reset, sample_accept, !q_empty)

endmodule

FILE: design/psp_front.sv
module psp_front import psp_pkg::*; #(
   parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
   psp_req_if.sink         req_chan,
   input  logic            beat_allowed,
   input  logic            q_full,
   output logic            push,
   output queue_entry_type push_entry
);

   logic keep;

   // beats that cannot start playback, stray loads and unused codes are dropped here
   always_comb begin
      keep                    = 1'b0;
      push_entry.op           = OP_SAMPLE;
      push_entry.load_address = req_chan.load_address;
      push_entry.load_data    = req_chan.load_data;
      case (req_chan.req_type)
         REQ_SAMPLE: begin
            keep          = 1'b1;
            push_entry.op = OP_SAMPLE;
         end
         REQ_BEAT: begin
            keep          = beat_allowed && !req_chan.muted;
            push_entry.op = OP_RESTART;
         end
         REQ_LOAD: begin
            keep          = int'(req_chan.load_address) < SAMPLE_DEPTH;
            push_entry.op = OP_LOAD;
         end
         default: begin
            keep          = 1'b0;
            push_entry.op = OP_SAMPLE;
         end
      endcase
   end

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full && keep;

endmodule

FILE: design/psp_queue.sv
module psp_queue import psp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output queue_entry_type head,
   output logic            empty
);

   queue_entry_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full  = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/psp_back.sv
module psp_back import psp_pkg::*; #(
   parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  queue_entry_type head,
   input  logic            q_empty,
   output logic            pop,
   input  play_cfg_type    play_cfg,
   psp_rsp_if.source       rsp_chan
);

   localparam int ADDR_W      = $clog2(SAMPLE_DEPTH);
   localparam int IDX_W       = ((ADDR_W > 5) ? ADDR_W : 5) + 1;
   localparam int POS_W       = IDX_W + FRAC_W;
   localparam int CMP_W       = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
   localparam int RESET_COUNT = (SAMPLE_DEPTH < 2048) ? SAMPLE_DEPTH : 2048;

   logic signed [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];

   back_state_type state_ff, state_in;

   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [ADDR_W-1:0]          next_addr_ff, next_addr_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic signed [SAMPLE_W-1:0] rdata_ff;

   logic                       x_valid_ff, x_valid_in;
   logic                       x_silent_ff, x_silent_in;
   logic [FRAC_W-1:0]          x_frac_ff, x_frac_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] audio_ff, audio_in;
   logic                       playing_ff, playing_in;

   logic [IDX_W-1:0]  idx;
   logic              silent;
   logic              out_free;
   logic              x_free;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic              pos_zero;
   logic              pos_adv;
   logic              take_silent;
   logic              take_interp;

   logic signed [SAMPLE_W:0]       diff;
   logic signed [2*SAMPLE_W+1:0]   prod;
   logic signed [SAMPLE_W+1:0]     sum;

   assign idx      = pos_ff[POS_W-1:FRAC_W];
   assign silent   = (CMP_W'(idx) + CMP_W'(1)) >= CMP_W'(play_cfg.eff_count);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign x_free   = !x_valid_ff || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_FIRST: begin
            if (!q_empty && head.op == OP_SAMPLE && !silent && x_free) begin
               state_in = BK_SECOND;
            end
         end
         BK_SECOND: begin
            if (x_free) begin
               state_in = BK_FIRST;
            end
         end
         default: state_in = BK_FIRST;
      endcase
   end

   // state outputs
   always_comb begin
      pop         = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx[ADDR_W-1:0];
      wr_en       = 1'b0;
      pos_zero    = 1'b0;
      pos_adv     = 1'b0;
      take_silent = 1'b0;
      take_interp = 1'b0;
      case (state_ff)
         BK_FIRST: begin
            if (!q_empty) begin
               case (head.op)
                  OP_LOAD: begin
                     pop   = 1'b1;
                     wr_en = 1'b1;
                  end
                  OP_RESTART: begin
                     pop      = 1'b1;
                     pos_zero = 1'b1;
                  end
                  OP_SAMPLE: begin
                     if (x_free) begin
                        pop = 1'b1;
                        if (silent) begin
                           take_silent = 1'b1;
                        end else begin
                           rd_en   = 1'b1;
                           pos_adv = 1'b1;
                        end
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BK_SECOND: begin
            if (x_free) begin
               rd_en       = 1'b1;
               rd_addr     = next_addr_ff;
               take_interp = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // position never wraps: it only advances while below the last pair
   always_comb begin
      pos_in       = pos_ff;
      next_addr_in = next_addr_ff;
      frac_in      = frac_ff;
      if (pos_zero) begin
         pos_in = '0;
      end else if (pos_adv) begin
         pos_in       = pos_ff + POS_W'(play_cfg.step);
         next_addr_in = idx[ADDR_W-1:0] + 1'b1;
         frac_in      = pos_ff[FRAC_W-1:0];
      end
   end

   always_comb begin
      x_valid_in  = x_valid_ff;
      x_silent_in = x_silent_ff;
      x_frac_in   = x_frac_ff;
      a_in        = a_ff;
      if (take_silent) begin
         x_valid_in  = 1'b1;
         x_silent_in = 1'b1;
      end else if (take_interp) begin
         x_valid_in  = 1'b1;
         x_silent_in = 1'b0;
         x_frac_in   = frac_ff;
         a_in        = rdata_ff;
      end else if (out_free) begin
         x_valid_in = 1'b0;
      end
   end

   // rdata_ff holds the upper sample b while x holds the item
   always_comb begin
      diff = (SAMPLE_W+1)'(rdata_ff) - (SAMPLE_W+1)'(a_ff);
      prod = (2*SAMPLE_W+2)'(diff) * (2*SAMPLE_W+2)'($signed({1'b0, x_frac_ff}));
      sum  = (SAMPLE_W+2)'(a_ff) + $signed(prod[2*SAMPLE_W+1:FRAC_W]);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      audio_in     = audio_ff;
      playing_in   = playing_ff;
      if (out_free) begin
         rsp_valid_in = x_valid_ff;
         audio_in     = x_silent_ff ? '0 : sum[SAMPLE_W-1:0];
         playing_in   = !x_silent_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FIRST;
         pos_ff       <= POS_W'(RESET_COUNT) << FRAC_W;
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_addr_ff <= next_addr_in;
      frac_ff      <= frac_in;
      x_silent_ff  <= x_silent_in;
      x_frac_ff    <= x_frac_in;
      a_ff         <= a_in;
      audio_ff     <= audio_in;
      playing_ff   <= playing_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ADDR_W'(head.load_address)] <= head.load_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.audio_sample = audio_ff;
   assign rsp_chan.playing      = playing_ff;

endmodule
